// ----- rtl/assert_macros.svh -----
// Assertion helper macros for the mid/side stereo widener RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on the rising clock edge, ignored while reset is asserted.
`define MSW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the rising clock edge, also active during reset.
`define MSW_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/msw_pkg.sv -----
// Package for the mid/side stereo widener: constants, register indexes,
// microcode field codes and the control store. No dependencies.
`timescale 1ns / 1ps

package msw_pkg;

    // Default sizes and fixed formats
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_BITS_DEF  = 16;
    localparam int ACC_W           = 32;
    localparam int MUL_A_W         = 36;   // widest operand: mid + rebuilt side
    localparam int GAIN_W          = 16;
    localparam int GAIN_FRAC       = 14;
    localparam int GAIN_ONE        = 16384;
    localparam int WIDTH_W         = 15;
    localparam int WIDTH_MAX       = 24576;
    localparam int WIDTH_RST       = 16384;
    localparam int BAL_W           = 16;
    localparam int LOW_COEFF_RST   = 1700;
    localparam int CFG_IDX_W       = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MONO_BELOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_COEFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE    = 3'd6;

    // Step counter
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_EMIT = 4'd12;

    // Work register operation
    localparam logic [1:0] T_NONE    = 2'd0;
    localparam logic [1:0] T_DIFF_LO = 2'd1;   // side - acc_lo
    localparam logic [1:0] T_DIFF_HI = 2'd2;   // side - acc_lo - acc_hi
    localparam logic [1:0] T_SUM     = 2'd3;   // low part + widened high part

    // Multiplier A operand
    localparam logic [1:0] MA_T      = 2'd0;
    localparam logic [1:0] MA_ACC_HI = 2'd1;
    localparam logic [1:0] MA_U      = 2'd2;
    localparam logic [1:0] MA_V      = 2'd3;

    // Multiplier B operand
    localparam logic [2:0] MB_LOW  = 3'd0;
    localparam logic [2:0] MB_HIGH = 3'd1;
    localparam logic [2:0] MB_WG   = 3'd2;
    localparam logic [2:0] MB_GL   = 3'd3;
    localparam logic [2:0] MB_GR   = 3'd4;

    // Accumulator write-back
    localparam logic [1:0] AW_NONE = 2'd0;
    localparam logic [1:0] AW_LO   = 2'd1;
    localparam logic [1:0] AW_HI   = 2'd2;

    // Sequencing
    localparam logic [1:0] SQ_NEXT = 2'd0;
    localparam logic [1:0] SQ_BYP  = 2'd1;   // jump to target when bypass is set
    localparam logic [1:0] SQ_EMIT = 2'd2;   // hand result out, then go idle
    localparam logic [1:0] SQ_JUMP = 2'd3;

    typedef struct packed {
        logic [1:0]        t_op;
        logic [1:0]        ma;
        logic [2:0]        mb;
        logic              mul_en;
        logic [1:0]        acc_wr;
        logic              split;
        logic              rebuild;
        logic              outl;
        logic [1:0]        seq;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Control store: one control word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        case (step)
            4'd0: begin
                w.split  = 1'b1;
                w.seq    = SQ_BYP;
                w.target = STEP_EMIT;
            end
            4'd1: begin
                w.t_op = T_DIFF_LO;
            end
            4'd2: begin
                w.ma     = MA_T;
                w.mb     = MB_LOW;
                w.mul_en = 1'b1;
            end
            4'd3: begin
                w.acc_wr = AW_LO;
            end
            4'd4: begin
                w.t_op = T_DIFF_HI;
            end
            4'd5: begin
                w.ma     = MA_T;
                w.mb     = MB_HIGH;
                w.mul_en = 1'b1;
            end
            4'd6: begin
                w.acc_wr = AW_HI;
            end
            4'd7: begin
                w.ma     = MA_ACC_HI;
                w.mb     = MB_WG;
                w.mul_en = 1'b1;
            end
            4'd8: begin
                w.t_op = T_SUM;
            end
            4'd9: begin
                w.rebuild = 1'b1;
            end
            4'd10: begin
                w.ma     = MA_U;
                w.mb     = MB_GL;
                w.mul_en = 1'b1;
            end
            4'd11: begin
                w.ma     = MA_V;
                w.mb     = MB_GR;
                w.mul_en = 1'b1;
                w.outl   = 1'b1;
            end
            4'd12: begin
                w.seq = SQ_EMIT;
            end
            default: begin
                w.seq    = SQ_JUMP;
                w.target = STEP_EMIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/msw_if.sv -----
// Channel interfaces for the mid/side stereo widener: sample input,
// sample output and configuration write. Depends on nothing.
`timescale 1ns / 1ps

interface msw_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface msw_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface msw_cfg_if #(parameter int IDX_W = 3, parameter int DATA_W = 16);
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mid_side_stereo_widener_top.sv -----
// Mid/side stereo widener top level: microcoded sequencer over one shared
// multiplier. Depends on msw_pkg, msw_if.sv and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   i_in  : one stereo pair per request (left_in, right_in, signed Q3.20).
//   o_out : one processed pair per accepted input, in order.
//   i_cfg : register writes (index, data); always ready, write only while idle.
// Sequencing
//   A pair runs through a 13-step control program that shares one
//   multiplier (filter updates, width gain, two balance gains); in bypass
//   the program jumps from its first step straight to its last.
//   The next pair is accepted in the cycle the current result is loaded,
//   so no new pair is taken while the current one is still in the program.
// Reset
//   Synchronous, active low: the sequencer goes idle, the output register
//   empties, both filter accumulators clear and registers take their defaults.
// Backpressure
//   The result waits in the output register. The sequencer holds on its
//   last step until that register is free, and no new pair is accepted
//   until then.

module mid_side_stereo_widener_top #(
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = msw_pkg::COEFF_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msw_in_if.sink      i_in,
    msw_out_if.source   o_out,
    msw_cfg_if.sink     i_cfg
);
    import msw_pkg::*;

    localparam int MUL_B_W = ((COEFF_BITS > WIDTH_W) ? COEFF_BITS : WIDTH_W) + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int FILT_W  = PROD_W - COEFF_BITS + 1;

    localparam logic signed [PROD_W-1:0] HALF_C = PROD_W'(1) <<< (COEFF_BITS - 1);
    localparam logic signed [PROD_W-1:0] HALF_G = PROD_W'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [PROD_W-1:0] FOUR_P = PROD_W'(1) <<< (SAMPLE_BITS - 2);
    localparam logic signed [FILT_W-1:0] ACC_MAX_F = (FILT_W'(1) <<< (ACC_W - 1)) - 1;
    localparam logic signed [FILT_W-1:0] ACC_MIN_F = -(FILT_W'(1) <<< (ACC_W - 1));

    // Configuration registers
    logic                     r_bypass;
    logic                     r_stereo;
    logic                     r_mono_below;
    logic [COEFF_BITS-1:0]    r_low_coeff;
    logic [COEFF_BITS-1:0]    r_high_coeff;
    logic [WIDTH_W-1:0]       r_width_gain;
    logic signed [BAL_W-1:0]  r_balance;

    // Sequencer state
    logic                     r_busy;
    logic [STEP_W-1:0]        r_step;
    t_uword                   w_uw;

    // Datapath
    logic signed [SAMPLE_BITS-1:0] r_l, r_rin, r_mid, r_side, r_out_l;
    logic signed [ACC_W-1:0]       r_acc_lo, r_acc_hi;
    logic signed [MUL_A_W-1:0]     r_t, r_u, r_v;
    logic signed [PROD_W-1:0]      r_p;

    // Output register
    logic                          r_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_o_left, r_o_right;

    logic                          w_in_fire, w_emit_fire, w_cfg_fire;
    logic signed [SAMPLE_BITS-1:0] w_r;
    logic signed [SAMPLE_BITS:0]   w_sum, w_dif;
    logic signed [MUL_A_W-1:0]     w_ma, n_t;
    logic signed [MUL_B_W-1:0]     w_mb;
    logic [GAIN_W-1:0]             w_gl, w_gr;
    logic [WIDTH_W-1:0]            w_wg;
    logic signed [PROD_W-1:0]      w_p_rc, w_p_rg, w_p_clamp;
    logic signed [ACC_W-1:0]       w_acc_src, n_acc;
    logic signed [FILT_W-1:0]      w_filt;
    logic signed [SAMPLE_BITS-1:0] n_o_left, n_o_right;

    // Handshakes
    assign w_uw        = ucode(r_step);
    assign w_emit_fire = r_busy && (w_uw.seq == SQ_EMIT) && (!r_o_valid || o_out.ready);
    assign i_in.ready  = !r_busy || w_emit_fire;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign w_cfg_fire  = i_cfg.valid && i_cfg.ready;

    assign o_out.valid     = r_o_valid;
    assign o_out.left_out  = r_o_left;
    assign o_out.right_out = r_o_right;

    // Mid/side split
    assign w_r   = r_stereo ? r_rin : r_l;
    assign w_sum = {r_l[SAMPLE_BITS-1], r_l} + {w_r[SAMPLE_BITS-1], w_r};
    assign w_dif = {r_l[SAMPLE_BITS-1], r_l} - {w_r[SAMPLE_BITS-1], w_r};

    // Gains: clamped width, balance split into left and right
    assign w_wg = (r_width_gain > WIDTH_MAX) ? WIDTH_W'(WIDTH_MAX) : r_width_gain;

    always_comb begin
        if (r_balance <= 0) begin
            w_gl = GAIN_W'(GAIN_ONE);
        end else if (r_balance >= GAIN_ONE) begin
            w_gl = '0;
        end else begin
            w_gl = GAIN_W'(GAIN_ONE - r_balance);
        end
        if (r_balance >= 0) begin
            w_gr = GAIN_W'(GAIN_ONE);
        end else if (r_balance <= -GAIN_ONE) begin
            w_gr = '0;
        end else begin
            w_gr = GAIN_W'(GAIN_ONE + r_balance);
        end
    end

    // Rounded product views
    assign w_p_rc = (r_p + HALF_C) >>> COEFF_BITS;
    assign w_p_rg = (r_p + HALF_G) >>> GAIN_FRAC;

    always_comb begin
        if (w_p_rg > FOUR_P) begin
            w_p_clamp = FOUR_P;
        end else if (w_p_rg < -FOUR_P) begin
            w_p_clamp = -FOUR_P;
        end else begin
            w_p_clamp = w_p_rg;
        end
    end

    // Filter update with saturation to the accumulator width
    assign w_acc_src = (w_uw.acc_wr == AW_HI) ? r_acc_hi : r_acc_lo;
    assign w_filt    = FILT_W'(w_acc_src) + FILT_W'(w_p_rc);

    always_comb begin
        if (w_filt > ACC_MAX_F) begin
            n_acc = ACC_W'(ACC_MAX_F);
        end else if (w_filt < ACC_MIN_F) begin
            n_acc = ACC_W'(ACC_MIN_F);
        end else begin
            n_acc = ACC_W'(w_filt);
        end
    end

    // Work register source
    always_comb begin
        case (w_uw.t_op)
            T_DIFF_LO: n_t = MUL_A_W'(r_side) - MUL_A_W'(r_acc_lo);
            T_DIFF_HI: n_t = MUL_A_W'(r_side) - MUL_A_W'(r_acc_lo)
                           - MUL_A_W'(r_acc_hi);
            T_SUM:     n_t = (r_mono_below ? '0 : MUL_A_W'(r_acc_lo))
                           + MUL_A_W'(w_p_rg);
            default:   n_t = r_t;
        endcase
    end

    // Multiplier operand selection
    always_comb begin
        case (w_uw.ma)
            MA_T:      w_ma = r_t;
            MA_ACC_HI: w_ma = MUL_A_W'(r_acc_hi);
            MA_U:      w_ma = r_u;
            MA_V:      w_ma = r_v;
            default:   w_ma = r_t;
        endcase
        case (w_uw.mb)
            MB_LOW:  w_mb = MUL_B_W'(r_low_coeff);
            MB_HIGH: w_mb = MUL_B_W'(r_high_coeff);
            MB_WG:   w_mb = MUL_B_W'(w_wg);
            MB_GL:   w_mb = MUL_B_W'(w_gl);
            MB_GR:   w_mb = MUL_B_W'(w_gr);
            default: w_mb = '0;
        endcase
    end

    // Result selection at emit
    assign n_o_left  = r_bypass ? r_l : r_out_l;
    assign n_o_right = (r_bypass || !r_stereo) ? r_rin : SAMPLE_BITS'(w_p_clamp);

    // Control state, filter state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_step       <= '0;
            r_o_valid    <= 1'b0;
            r_acc_lo     <= '0;
            r_acc_hi     <= '0;
            r_bypass     <= 1'b0;
            r_stereo     <= 1'b1;
            r_mono_below <= 1'b0;
            r_low_coeff  <= COEFF_BITS'(LOW_COEFF_RST);
            r_high_coeff <= '1;
            r_width_gain <= WIDTH_W'(WIDTH_RST);
            r_balance    <= '0;
        end else begin
            // sequencer
            if (w_in_fire) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (w_emit_fire) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                case (w_uw.seq)
                    SQ_NEXT: r_step <= r_step + 1'b1;
                    SQ_BYP:  r_step <= r_bypass ? w_uw.target : r_step + 1'b1;
                    SQ_JUMP: r_step <= w_uw.target;
                    default: r_step <= r_step;
                endcase
            end

            // output register
            if (w_emit_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            // filter accumulators
            if (r_busy && (w_uw.acc_wr == AW_LO)) begin
                r_acc_lo <= n_acc;
            end
            if (r_busy && (w_uw.acc_wr == AW_HI)) begin
                r_acc_hi <= n_acc;
            end

            // configuration writes
            if (w_cfg_fire) begin
                case (i_cfg.index)
                    REG_BYPASS:     r_bypass     <= i_cfg.data[0];
                    REG_STEREO:     r_stereo     <= i_cfg.data[0];
                    REG_MONO_BELOW: r_mono_below <= i_cfg.data[0];
                    REG_LOW_COEFF:  r_low_coeff  <= COEFF_BITS'(i_cfg.data);
                    REG_HIGH_COEFF: r_high_coeff <= COEFF_BITS'(i_cfg.data);
                    REG_WIDTH_GAIN: r_width_gain <= i_cfg.data[WIDTH_W-1:0];
                    REG_BALANCE:    r_balance    <= i_cfg.data[BAL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_l   <= i_in.left_in;
            r_rin <= i_in.right_in;
        end
        if (r_busy) begin
            if (w_uw.split) begin
                r_mid  <= w_sum[SAMPLE_BITS:1];
                r_side <= w_dif[SAMPLE_BITS:1];
            end
            r_t <= n_t;
            if (w_uw.rebuild) begin
                r_u <= MUL_A_W'(r_mid) + r_t;
                r_v <= MUL_A_W'(r_mid) - r_t;
            end
            if (w_uw.mul_en) begin
                r_p <= w_ma * w_mb;
            end
            if (w_uw.outl) begin
                r_out_l <= SAMPLE_BITS'(w_p_clamp);
            end
        end
        if (w_emit_fire) begin
            r_o_left  <= n_o_left;
            r_o_right <= n_o_right;
        end
    end

    // Assertions
    `MSW_ASSERT(a_step_range, i_clk, i_rst_n, r_busy |-> (r_step <= STEP_EMIT),
        "step counter left the control program")
    `MSW_ASSERT(a_start, i_clk, i_rst_n, w_in_fire |=> (r_busy && (r_step == '0)),
        "accepted request did not start the program at step zero")
    `MSW_ASSERT(a_emit, i_clk, i_rst_n, w_emit_fire |=> r_o_valid,
        "emitted result missing from the output register")
    `MSW_ASSERT(a_bypass_hold, i_clk, i_rst_n,
        (r_busy && r_bypass) |=> ($stable(r_acc_lo) && $stable(r_acc_hi)),
        "filter state changed during a bypassed request")
    `MSW_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !r_o_valid,
        "output register not empty after reset")

endmodule
